// ===== rtl/b32d_pkg.sv =====
// b32d_pkg: shared types and constants for the base32 stream decoder.
// No dependencies; imported by every module of the block.
package b32d_pkg;

    localparam int SYM_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_LENGTH   = 2'd1;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd2;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_DIGIT_2 = 8'h32;
    localparam logic [7:0] CHAR_DIGIT_7 = 8'h37;
    // '2' maps to 26, so digits map by subtracting '2' - 26
    localparam logic [7:0] DIGIT_OFFSET = 8'd24;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             bad;
        logic             last;
    } b32d_item_t;

endpackage

// ===== rtl/b32d_front.sv =====
// b32d_front: classifies each incoming character into a 5-bit symbol and a bad flag.
// Depends on b32d_pkg; feeds b32d_queue.
module b32d_front
    import b32d_pkg::*;
(
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    output logic       push,
    output b32d_item_t push_item,
    input  logic       push_ready
);

    logic             is_alpha;
    logic             is_digit;
    logic [BYTE_W-1:0] digit_val;

    assign is_alpha  = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z);
    assign is_digit  = (char_code >= CHAR_DIGIT_2) && (char_code <= CHAR_DIGIT_7);
    assign digit_val = char_code - DIGIT_OFFSET;

    always_comb
    begin
        push_item.last = end_of_text;
        push_item.bad  = !(is_alpha || is_digit);
        if (is_alpha)
        begin
            push_item.sym = char_code[SYM_W-1:0] - CHAR_UPPER_A[SYM_W-1:0];
        end
        else if (is_digit)
        begin
            push_item.sym = digit_val[SYM_W-1:0];
        end
        else
        begin
            push_item.sym = '0;
        end
    end

    assign in_ready = push_ready;
    assign push     = in_valid;

endmodule

// ===== rtl/b32d_queue.sv =====
// b32d_queue: short FIFO of classified items between front and back.
// Depends on b32d_pkg.
module b32d_queue
    import b32d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  b32d_item_t push_item,
    output logic       push_ready,
    input  logic       pop,
    output b32d_item_t pop_item,
    output logic       pop_valid
);

    b32d_item_t         mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;
    assign pop_item   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (do_pop && !do_push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue pop did not drop count");
`endif

endmodule

// ===== rtl/b32d_back.sv =====
// b32d_back: bit accumulator, byte extraction, final status and output register.
// Depends on b32d_pkg; drains b32d_queue.
module b32d_back
    import b32d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    input  b32d_item_t pop_item,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic [1:0] status,
    output logic       is_final
);

    logic [6:0]  bit_buffer_reg, bit_buffer_next;
    logic [2:0]  bit_count_reg, bit_count_next;
    logic [2:0]  char_phase_reg, char_phase_next;
    logic        bad_seen_reg, bad_seen_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  data_byte_reg, data_byte_next;
    logic        byte_valid_reg, byte_valid_next;
    logic [1:0]  status_reg, status_next;
    logic        is_final_reg, is_final_next;

    logic [11:0] acc;
    logic [3:0]  cnt;
    logic [3:0]  rest;
    logic [11:0] shifted;
    logic [2:0]  new_count;
    logic [6:0]  keep_mask;
    logic        have_byte;
    logic        emit;

    assign pop     = pop_valid && (!out_valid_reg || out_ready);
    assign acc     = {bit_buffer_reg, pop_item.sym};
    assign cnt     = {1'b0, bit_count_reg} + 4'd5;
    assign rest    = cnt - 4'd8;
    assign shifted = acc >> rest;

    always_comb
    begin
        bit_buffer_next = bit_buffer_reg;
        bit_count_next  = bit_count_reg;
        bad_seen_next   = bad_seen_reg;
        char_phase_next = char_phase_reg + 1'b1;
        have_byte       = 1'b0;
        new_count       = cnt[2:0];
        keep_mask       = '0;
        data_byte_next  = '0;
        if (pop_item.bad)
        begin
            bad_seen_next = 1'b1;
        end
        else if (!bad_seen_reg)
        begin
            if (cnt >= 4'd8)
            begin
                have_byte      = 1'b1;
                data_byte_next = shifted[7:0];
                new_count      = rest[2:0];
            end
            keep_mask       = 7'((8'd1 << new_count) - 8'd1);
            bit_count_next  = new_count;
            bit_buffer_next = acc[6:0] & keep_mask;
        end

        is_final_next = pop_item.last;
        status_next   = STATUS_OK;
        if (pop_item.last)
        begin
            if (char_phase_next != 3'd0)
            begin
                status_next = STATUS_LENGTH;
            end
            else if (bad_seen_next)
            begin
                status_next = STATUS_BAD_CHAR;
            end
            if (status_next != STATUS_OK)
            begin
                have_byte      = 1'b0;
                data_byte_next = '0;
            end
            bit_buffer_next = '0;
            bit_count_next  = '0;
            char_phase_next = '0;
            bad_seen_next   = 1'b0;
        end
        byte_valid_next = have_byte;
        emit            = pop_item.last || have_byte;

        out_valid_next = out_valid_reg && !out_ready;
        if (pop && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_buffer_reg <= '0;
            bit_count_reg  <= '0;
            char_phase_reg <= '0;
            bad_seen_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                bit_buffer_reg <= bit_buffer_next;
                bit_count_reg  <= bit_count_next;
                char_phase_reg <= char_phase_next;
                bad_seen_reg   <= bad_seen_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            data_byte_reg  <= data_byte_next;
            byte_valid_reg <= byte_valid_next;
            status_reg     <= status_next;
            is_final_reg   <= is_final_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_byte  = data_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign status     = status_reg;
    assign is_final   = is_final_reg;

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && pop_item.last) |=>
            (bit_count_reg == '0 && char_phase_reg == '0 && !bad_seen_reg))
        else $error("string state not cleared after last item");
    a_nonfinal_is_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !is_final_reg) |-> (byte_valid_reg && status_reg == STATUS_OK))
        else $error("non-final result without byte or with status");
    a_error_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STATUS_OK) |-> (!byte_valid_reg && data_byte_reg == '0))
        else $error("byte carried on error status");
    a_no_pop_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !pop)
        else $error("item drained while result stalled");
`endif

endmodule

// ===== rtl/base32_stream_decoder.sv =====
// Base32 stream decoder: one character per item, one byte or final status per result.
// An accepted character is written into the queue, then drained into the output register that drives out_valid.
// Throughput: one character per cycle while out_ready is held high; a 2-entry queue decouples the two sides.
// Reset: rst_n asynchronous active low clears queue, string state and output valid.
// Depends on b32d_pkg, b32d_front, b32d_queue, b32d_back.
module base32_stream_decoder
    import b32d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic [1:0] status,
    output logic       is_final
);

    logic       push;
    logic       push_ready;
    b32d_item_t push_item;
    logic       pop;
    logic       pop_valid;
    b32d_item_t pop_item;

    b32d_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .push        (push),
        .push_item   (push_item),
        .push_ready  (push_ready)
    );

    b32d_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid)
    );

    b32d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .is_final   (is_final)
    );

endmodule

// ===== tb/tb_base32_stream_decoder.sv =====
// Self-checking testbench for base32_stream_decoder: directed strings, then random
// well-formed, broken and noise strings, with random idling on both handshakes.
// Depends on b32d_pkg and the base32_stream_decoder RTL.
module tb_base32_stream_decoder
    import b32d_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 500;
    localparam int DIR_ROWS     = 25;
    localparam int IDLE_PCT     = 28;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [1:0] stat;
        logic       fin;
    } dec_result_t;

    typedef struct packed {
        logic [7:0]  code;
        logic        last;
        logic        typed;
        dec_result_t res;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_code = 8'h00;
    logic       end_of_text = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       is_final;

    logic [6:0] acc_bits;
    logic [2:0] acc_cnt;
    logic [2:0] str_phase;
    logic       str_bad;

    dec_result_t pending_results[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    bit          no_idle = 1'b0;

    // typed rows supply their expected result; for the rest it comes from decode_char
    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h37, 1'b1, 1'b1, '{8'hFF, 1'b1, STATUS_OK, 1'b1}},
        '{8'h3D, 1'b1, 1'b1, '{8'h00, 1'b0, STATUS_LENGTH, 1'b1}},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'h40, 1'b0, 1'b0, '0},
        '{8'h5B, 1'b0, 1'b0, '0},
        '{8'h31, 1'b0, 1'b0, '0},
        '{8'h38, 1'b0, 1'b0, '0},
        '{8'h3D, 1'b0, 1'b0, '0},
        '{8'h61, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, STATUS_BAD_CHAR, 1'b1}},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h5A, 1'b0, 1'b0, '0},
        '{8'h32, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h37, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h41, 1'b1, 1'b0, '0}
    };

    base32_stream_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .status      (status),
        .is_final    (is_final)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] symbol_char(input int unsigned v);
        if (v < 26)
            return 8'h41 + 8'(v);
        return 8'h32 + 8'(v - 26);
    endfunction

    function automatic logic [7:0] pick_bad_char();
        logic [7:0] c;
        if ($urandom_range(2) == 0)
            return 8'h3D;
        do
            c = 8'($urandom_range(255));
        while ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h32 && c <= 8'h37));
        return c;
    endfunction

    // advances the string state by one character; returns 1 when a result is due
    function automatic bit decode_char(input logic [7:0] code, input logic last,
                                       output dec_result_t r);
        logic [4:0]  sym;
        logic        is_sym;
        logic [11:0] wide;
        logic [7:0]  byte_out;
        logic        got;
        logic [1:0]  st;
        int          n;
        is_sym   = 1'b1;
        got      = 1'b0;
        byte_out = 8'h00;
        r        = '0;
        if (code >= 8'h41 && code <= 8'h5A)
            sym = 5'(code - 8'h41);
        else if (code >= 8'h32 && code <= 8'h37)
            sym = 5'(code - 8'h32 + 8'd26);
        else
        begin
            sym    = 5'd0;
            is_sym = 1'b0;
        end
        if (!is_sym)
            str_bad = 1'b1;
        else if (!str_bad)
        begin
            wide = {acc_bits, sym};
            n    = int'(acc_cnt) + 5;
            if (n >= 8)
            begin
                n        = n - 8;
                byte_out = 8'(wide >> n);
                got      = 1'b1;
            end
            acc_cnt  = 3'(n);
            acc_bits = 7'(wide & ((12'd1 << n) - 12'd1));
        end
        str_phase = str_phase + 3'd1;
        if (last)
        begin
            if (str_phase != 3'd0)
                st = STATUS_LENGTH;
            else if (str_bad)
                st = STATUS_BAD_CHAR;
            else
                st = STATUS_OK;
            if (st != STATUS_OK)
            begin
                got      = 1'b0;
                byte_out = 8'h00;
            end
            r         = '{byte_out, got, st, 1'b1};
            acc_bits  = '0;
            acc_cnt   = '0;
            str_phase = '0;
            str_bad   = 1'b0;
            return 1'b1;
        end
        if (got)
        begin
            r = '{byte_out, 1'b1, STATUS_OK, 1'b0};
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < IDLE_PCT);
    endfunction

    task automatic send_char(input logic [7:0] code, input logic last,
                             input logic typed, input dec_result_t typed_res);
        dec_result_t r;
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        char_code   <= code;
        end_of_text <= last;
        do
            @(posedge clk);
        while (!in_ready);
        if (decode_char(code, last, r))
            pending_results.insert(pending_results.size(), typed ? typed_res : r);
        items_sent++;
    endtask

    // kind: 0 well-formed, 1 random length of 1 to 19, 2 one bad character, 3 noise
    task automatic send_string(input int kind);
        int          len;
        int          bad_pos;
        logic [7:0]  c;
        logic        last;
        case (kind)
            0: len = ($urandom_range(9) == 0) ? 40 : 8 * $urandom_range(1, 4);
            1: len = $urandom_range(1, 19);
            2: len = 8 * $urandom_range(1, 3);
            default: len = $urandom_range(1, 12);
        endcase
        bad_pos = $urandom_range(len - 1);
        for (int i = 0; i < len; i++)
        begin
            c    = symbol_char($urandom_range(31));
            last = (i == len - 1);
            if (kind == 2 && i == bad_pos)
                c = pick_bad_char();
            if (kind == 3)
            begin
                c    = 8'($urandom_range(255));
                last = last | ($urandom_range(7) == 0);
            end
            send_char(c, last, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result data=%02h valid=%b status=%0d final=%b",
                         $time, data_byte, byte_valid, status, is_final);
                mismatch_count++;
            end
            else
            begin
                dec_result_t want;
                want = pending_results.pop_front();
                if ({data_byte, byte_valid, status, is_final} !== want)
                begin
                    $display("%0t: expected %02h/%b/%0d/%b actual %02h/%b/%0d/%b",
                             $time, want.data, want.valid, want.stat, want.fin,
                             data_byte, byte_valid, status, is_final);
                    mismatch_count++;
                end
            end
        end
        out_ready <= !idle_now();
    end

    initial
    begin
        bit paused;
        paused    = 1'b0;
        acc_bits  = '0;
        acc_cnt   = '0;
        str_phase = '0;
        str_bad   = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_char(dir_rows[i].code, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);

        while (items_sent < DIR_ROWS + RANDOM_ITEMS)
        begin
            int roll;
            no_idle = (items_sent >= DIR_ROWS + 150) && (items_sent < DIR_ROWS + 250);
            if (!paused && items_sent >= DIR_ROWS + 300)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (pending_results.size() != 0);
                paused = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 60)
                send_string(0);
            else if (roll < 75)
                send_string(1);
            else if (roll < 90)
                send_string(2);
            else
                send_string(3);
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
